FILE: rtl/core/lfs_pkg.sv
// Shared types and constants for the length-prefixed frame splitter.
`default_nettype none

package lfs_pkg;

	localparam int unsigned HEADER_BYTES_DEF = 12;
	localparam int unsigned HDR_CNT_W        = 6;
	localparam int unsigned WORD_W           = 32;
	localparam logic [WORD_W-1:0] MAX_PAYLOAD_RST = 32'd67108864;

	// Header byte positions of the two big-endian length words.
	localparam logic [HDR_CNT_W-1:0] PAY_FIRST  = 6'd4;
	localparam logic [HDR_CNT_W-1:0] PAY_LAST   = 6'd7;
	localparam logic [HDR_CNT_W-1:0] META_FIRST = 6'd8;
	localparam logic [HDR_CNT_W-1:0] META_LAST  = 6'd11;

	typedef enum logic [1:0] {
		SEC_HEADER  = 2'd0,
		SEC_META    = 2'd1,
		SEC_MESSAGE = 2'd2,
		SEC_DISCARD = 2'd3
	} section_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_TOO_BIG  = 2'd1,
		ERR_BAD_META = 2'd2
	} err_t;

	typedef struct packed {
		logic [7:0]        byte_out;
		section_t          section;
		logic [WORD_W-1:0] section_offset;
		logic              frame_done;
		logic              header_done;
		logic [WORD_W-1:0] meta_length;
		logic [WORD_W-1:0] message_length;
		err_t              err_code;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/core/lfs_in_stage.sv
// Input register stage of the frame splitter.
`default_nettype none

module lfs_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] byte_value,
	input  wire logic       take,
	output logic            valid_s1,
	output logic [7:0]      byte_s1,
	output logic            fire
);
	import lfs_pkg::*;

	// The staged beat moves on whenever the result register can take it.
	assign fire     = valid_s1 && take;
	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= byte_value;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/lfs_parser.sv
// Frame parsing state and the per-byte tagging logic.
`default_nettype none

module lfs_parser #(
	parameter int unsigned HEADER_BYTES = lfs_pkg::HEADER_BYTES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      fire,
	input  wire logic [7:0]                byte_s1,
	input  wire logic [lfs_pkg::WORD_W-1:0] max_payload,
	output lfs_pkg::result_t               res
);
	import lfs_pkg::*;

	localparam logic [HDR_CNT_W-1:0] HdrCount = HDR_CNT_W'(HEADER_BYTES);
	localparam logic [HDR_CNT_W-1:0] HdrLast  = HDR_CNT_W'(HEADER_BYTES - 1);

	logic [HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
	logic [WORD_W-1:0]    pay_len_q, pay_len_d, pay_len_n;
	logic [WORD_W-1:0]    meta_len_q, meta_len_d, meta_len_n;
	logic [WORD_W-1:0]    body_cnt_q, body_cnt_d, body_inc;
	logic [WORD_W-1:0]    msg_len_q, msg_len_d, msg_len_n;
	err_t                 err_q, err_d;
	logic                 too_big, bad_meta, body_is_meta, body_end;

	always_comb begin
		pay_len_n  = pay_len_q;
		meta_len_n = meta_len_q;
		if (hdr_cnt_q >= PAY_FIRST && hdr_cnt_q <= PAY_LAST) begin
			pay_len_n = {pay_len_q[WORD_W-9:0], byte_s1};
		end
		if (hdr_cnt_q >= META_FIRST && hdr_cnt_q <= META_LAST) begin
			meta_len_n = {meta_len_q[WORD_W-9:0], byte_s1};
		end
	end

	// Length checks and the message length for the header's last byte.
	assign too_big   = pay_len_n >= max_payload;
	assign bad_meta  = meta_len_n > pay_len_n;
	assign msg_len_n = bad_meta ? '0 : (pay_len_n - meta_len_n);

	assign body_is_meta = body_cnt_q < meta_len_q;
	assign body_inc     = body_cnt_q + 1'b1;
	assign body_end     = body_inc >= pay_len_q;

	always_comb begin
		hdr_cnt_d  = hdr_cnt_q;
		pay_len_d  = pay_len_q;
		meta_len_d = meta_len_q;
		body_cnt_d = body_cnt_q;
		msg_len_d  = msg_len_q;
		err_d      = err_q;

		res                = '0;
		res.byte_out       = byte_s1;
		res.section        = SEC_DISCARD;

		if (err_q != ERR_NONE) begin
			res.meta_length    = meta_len_q;
			res.message_length = msg_len_q;
		end else if (hdr_cnt_q != HdrCount) begin
			res.section        = SEC_HEADER;
			res.section_offset = WORD_W'(hdr_cnt_q);
			pay_len_d          = pay_len_n;
			meta_len_d         = meta_len_n;
			hdr_cnt_d          = hdr_cnt_q + 1'b1;
			if (hdr_cnt_q == HdrLast) begin
				res.header_done    = 1'b1;
				res.meta_length    = meta_len_n;
				res.message_length = msg_len_n;
				body_cnt_d         = '0;
				msg_len_d          = msg_len_n;
				if (too_big) begin
					err_d = ERR_TOO_BIG;
				end else if (bad_meta) begin
					err_d = ERR_BAD_META;
				end else if (pay_len_n == '0) begin
					res.frame_done = 1'b1;
					hdr_cnt_d      = '0;
				end
			end
		end else begin
			if (body_is_meta) begin
				res.section        = SEC_META;
				res.section_offset = body_cnt_q;
			end else begin
				res.section        = SEC_MESSAGE;
				res.section_offset = body_cnt_q - meta_len_q;
			end
			res.meta_length    = meta_len_q;
			res.message_length = msg_len_q;
			body_cnt_d         = body_inc;
			if (body_end) begin
				res.frame_done = 1'b1;
				hdr_cnt_d      = '0;
				body_cnt_d     = '0;
			end
		end

		res.err_code = err_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q  <= '0;
			pay_len_q  <= '0;
			meta_len_q <= '0;
			body_cnt_q <= '0;
			msg_len_q  <= '0;
			err_q      <= ERR_NONE;
		end else if (fire) begin
			hdr_cnt_q  <= hdr_cnt_d;
			pay_len_q  <= pay_len_d;
			meta_len_q <= meta_len_d;
			body_cnt_q <= body_cnt_d;
			msg_len_q  <= msg_len_d;
			err_q      <= err_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/lfs_out_stage.sv
// Result register of the frame splitter.
`default_nettype none

module lfs_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire lfs_pkg::result_t res,
	input  wire logic             out_stall,
	output logic                  take,
	output logic                  out_valid,
	output lfs_pkg::result_t      res_q
);
	import lfs_pkg::*;

	// The register loads when it is empty or its beat leaves this cycle.
	assign take = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (take && fire) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/length_prefixed_frame_splitter_top.sv
// Top level of the length-prefixed frame splitter.
`default_nettype none

// The splitter takes a byte stream, one byte per beat, and tags each byte with
// its place in a frame. A frame opens with a header of HEADER_BYTES bytes;
// bytes 4 to 7 carry the payload length and bytes 8 to 11 the meta length,
// both big-endian. The payload follows: meta bytes first, then message bytes.
// Each result beat carries the byte, its section, its offset in that section,
// a header-done flag on the last header byte and a frame-done flag on the last
// byte of a frame. A payload length at or above max_payload, or a meta length
// larger than the payload length, puts the block into a sticky error state in
// which every later byte is marked discarded; only reset clears it. The block
// takes one byte every clock cycle while the input is not stalled. Each byte
// passes through the input register and then the result register, with the
// length compares and offset subtract in between. The input stalls only
// when both registers are full and the output is stalled.
// max_payload is written through the configuration channel, which is always
// ready, and should only be changed while no bytes are in flight.

module length_prefixed_frame_splitter_top #(
	parameter int unsigned HEADER_BYTES = lfs_pkg::HEADER_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  byte_value,

	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       byte_out,
	output logic [1:0]       section,
	output logic [31:0]      section_offset,
	output logic             frame_done,
	output logic             header_done,
	output logic [31:0]      meta_length,
	output logic [31:0]      message_length,
	output logic [1:0]       err_code,

	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);
	import lfs_pkg::*;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              fire;
	logic              take;
	logic [WORD_W-1:0] max_payload_q;
	result_t           res;
	result_t           res_q;

	// The single configuration register is writable in every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_payload_q <= cfg_data;
		end
	end

	lfs_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_value (byte_value),
		.take       (take),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1),
		.fire       (fire)
	);

	lfs_parser #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.byte_s1     (byte_s1),
		.max_payload (max_payload_q),
		.res         (res)
	);

	lfs_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res       (res),
		.out_stall (out_stall),
		.take      (take),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign byte_out       = res_q.byte_out;
	assign section        = res_q.section;
	assign section_offset = res_q.section_offset;
	assign frame_done     = res_q.frame_done;
	assign header_done    = res_q.header_done;
	assign meta_length    = res_q.meta_length;
	assign message_length = res_q.message_length;
	assign err_code       = res_q.err_code;

	// A frame can only complete while no error is pending.
	a_done_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> err_code == ERR_NONE)
		else $error("frame_done reported together with an error");

	// Discarded bytes appear only in the error state.
	a_discard_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && section == SEC_DISCARD |-> err_code != ERR_NONE)
		else $error("discarded byte without an error");

	// The header-done flag belongs to a header byte.
	a_hdone_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_done |-> section == SEC_HEADER)
		else $error("header_done outside the header");

	// Body offsets stay inside their section.
	a_meta_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && section == SEC_META |-> section_offset < meta_length)
		else $error("meta offset beyond meta length");

	a_msg_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && section == SEC_MESSAGE |-> section_offset < message_length)
		else $error("message offset beyond message length");

endmodule

`default_nettype wire

FILE: tb/tb_length_prefixed_frame_splitter_top.sv
// Self-checking testbench for the length-prefixed frame splitter top level.
`timescale 1ns / 100ps

module tb_length_prefixed_frame_splitter_top;

	import lfs_pkg::*;

	// The standard header: a free word, then the two length words.
	localparam int unsigned HDR_LEN     = HEADER_BYTES_DEF;
	// Minimum bytes per random phase; a phase always ends on a frame boundary.
	localparam int unsigned PHASE_BYTES = 380;
	// Cycles without any handshake before the run is declared hung.
	localparam int unsigned QUIET_LIMIT = 2000;
	// Length of the receiver hold-off that fills the pipeline.
	localparam int unsigned LONG_HOLD   = 80;
	// Extra wait after the final drain at the end, for stray result beats.
	localparam int unsigned TAIL_CYCLES = 10;

	// The scoreboard carries its own copy of the splitter state. Every byte
	// that the splitter accepts is run through the same frame parser here,
	// and the tag that it should produce is queued until the matching result
	// beat shows up on the output.
	class frame_tag_scoreboard_t;
		int unsigned hdr_len;
		int unsigned hdr_pos;
		logic [31:0] pay_sz;
		logic [31:0] meta_sz;
		logic [31:0] body_pos;
		logic [31:0] max_payload;
		err_t        sticky_err;
		result_t     tags_due[$];
		int unsigned fails;

		function new(int unsigned hl);
			hdr_len     = hl;
			hdr_pos     = 0;
			pay_sz      = '0;
			meta_sz     = '0;
			body_pos    = '0;
			max_payload = MAX_PAYLOAD_RST;
			sticky_err  = ERR_NONE;
			fails       = 0;
		endfunction

		// Message part of the payload; a meta word longer than the payload
		// leaves no message at all.
		function logic [31:0] msg_bytes();
			return (pay_sz >= meta_sz) ? pay_sz - meta_sz : '0;
		endfunction

		function void take_byte(logic [7:0] b);
			result_t t;
			t = '0;
			t.byte_out = b;
			t.section  = SEC_DISCARD;
			if (sticky_err != ERR_NONE) begin
				t.meta_length    = meta_sz;
				t.message_length = msg_bytes();
			end else if (hdr_pos < hdr_len) begin
				t.section        = SEC_HEADER;
				t.section_offset = hdr_pos;
				if (hdr_pos >= 4 && hdr_pos < 8)
					pay_sz = {pay_sz[23:0], b};
				else if (hdr_pos >= 8 && hdr_pos < 12)
					meta_sz = {meta_sz[23:0], b};
				hdr_pos++;
				if (hdr_pos == hdr_len) begin
					t.header_done = 1'b1;
					body_pos = '0;
					if (pay_sz >= max_payload) begin
						sticky_err = ERR_TOO_BIG;
					end else if (meta_sz > pay_sz) begin
						sticky_err = ERR_BAD_META;
					end else if (pay_sz == 0) begin
						t.frame_done = 1'b1;
						hdr_pos = 0;
					end
					t.meta_length    = meta_sz;
					t.message_length = msg_bytes();
				end
			end else begin
				if (body_pos < meta_sz) begin
					t.section        = SEC_META;
					t.section_offset = body_pos;
				end else begin
					t.section        = SEC_MESSAGE;
					t.section_offset = body_pos - meta_sz;
				end
				t.meta_length    = meta_sz;
				t.message_length = msg_bytes();
				body_pos = body_pos + 1;
				if (body_pos >= pay_sz) begin
					t.frame_done = 1'b1;
					hdr_pos  = 0;
					body_pos = '0;
				end
			end
			t.err_code = sticky_err;
			tags_due.push_back(t);
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
				fails++;
			end
		endfunction

		function void check_tag(result_t got);
			result_t want;
			if (tags_due.size() == 0) begin
				$error("result beat with byte 0x%0h arrived with no byte outstanding",
					got.byte_out);
				fails++;
				return;
			end
			want = tags_due.pop_front();
			field_check("byte_out", want.byte_out, got.byte_out);
			field_check("section", want.section, got.section);
			field_check("section_offset", want.section_offset, got.section_offset);
			field_check("frame_done", want.frame_done, got.frame_done);
			field_check("header_done", want.header_done, got.header_done);
			field_check("meta_length", want.meta_length, got.meta_length);
			field_check("message_length", want.message_length, got.message_length);
			field_check("err_code", want.err_code, got.err_code);
		endfunction
	endclass

	// Every input of the splitter starts at a known value at time zero.
	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_stall;
	logic [7:0]  byte_value = 8'h00;
	logic        out_valid;
	logic        out_stall  = 1'b0;
	logic [7:0]  byte_out;
	logic [1:0]  section;
	logic [31:0] section_offset;
	logic        frame_done;
	logic        header_done;
	logic [31:0] meta_length;
	logic [31:0] message_length;
	logic [1:0]  err_code;
	logic        cfg_valid  = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data   = '0;

	frame_tag_scoreboard_t sb;

	// Idling knobs. The sender percentage lives in the stimulus process only;
	// the receiver percentage and the hold-off request cross into the
	// receiver process and are therefore written with nonblocking assignments.
	int unsigned tx_idle_pct  = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned hold_req     = 0;
	int unsigned hold_ack     = 0;
	int unsigned hold_left    = 0;
	int unsigned phase_bytes  = 0;
	int unsigned quiet        = 0;

	length_prefixed_frame_splitter_top #(
		.HEADER_BYTES(HDR_LEN)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.byte_value    (byte_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.byte_out      (byte_out),
		.section       (section),
		.section_offset(section_offset),
		.frame_done    (frame_done),
		.header_done   (header_done),
		.meta_length   (meta_length),
		.message_length(message_length),
		.err_code      (err_code),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// 20 ns clock period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver. Normally it stalls at random with the current percentage.
	// When the stimulus asks for a hold-off, it keeps the output stalled for
	// a long stretch, counted here, so that both pipeline registers fill and
	// the splitter has to push back on its input.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_req != hold_ack) begin
			hold_ack  <= hold_req;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// Output monitor. The ports are read at the clock edge, before the
	// splitter's own updates for that edge land, so a beat counts exactly
	// when valid was high and stall low going into the edge.
	always @(posedge clk) begin : result_monitor
		result_t got;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			got.byte_out       = byte_out;
			got.section        = section_t'(section);
			got.section_offset = section_offset;
			got.frame_done     = frame_done;
			got.header_done    = header_done;
			got.meta_length    = meta_length;
			got.message_length = message_length;
			got.err_code       = err_t'(err_code);
			sb.check_tag(got);
		end
	end

	// Watchdog: any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Offer one byte, idling first at random, and hold it until the splitter
	// takes it. A byte that follows without a gap keeps valid high, so valid
	// only ever gets one assignment per clock edge.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		byte_value <= b;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		sb.take_byte(b);
		phase_bytes++;
	endtask

	// Stop offering and wait until every predicted result beat has come out.
	// At least one edge always passes, so that lowering valid here never
	// collides with raising it again in the same time step.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.tags_due.size() != 0);
	endtask

	// Change max_payload. Each result beat leaves only after its byte, so an
	// empty expectation queue means the splitter holds no byte in flight.
	task automatic write_max(input logic [31:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		sb.max_payload = v;
	endtask

	// One frame: the header with its two big-endian length words, then the
	// payload bytes unless only the header is wanted. A negative filler
	// means random content for the free header bytes and the payload.
	task automatic send_frame(input logic [31:0] pay, input logic [31:0] meta,
		input int filler, input bit hdr_only);
		logic [7:0]  b;
		int unsigned i;
		for (i = 0; i < HDR_LEN; i++) begin
			if (i >= 4 && i < 8)
				b = 8'(pay >> (8 * (7 - i)));
			else if (i >= 8 && i < 12)
				b = 8'(meta >> (8 * (11 - i)));
			else
				b = (filler < 0) ? 8'($urandom) : 8'(filler);
			send_byte(b);
		end
		if (!hdr_only) begin
			for (i = 0; i < pay; i++)
				send_byte((filler < 0) ? 8'($urandom) : 8'(filler));
		end
	endtask

	// A well-formed frame whose payload stays below max_payload. Most frames
	// are short; now and then one is long enough to use the third length
	// byte. The meta part is empty, the whole payload, or anything between.
	task automatic send_random_frame(input logic [31:0] cap);
		logic [31:0] pay;
		logic [31:0] meta;
		if ($urandom_range(15) == 0)
			pay = $urandom_range(300, 25);
		else
			pay = $urandom_range(24);
		if (pay > cap)
			pay = ($urandom_range(3) == 0) ? cap : $urandom_range(cap);
		case ($urandom_range(3))
			0: meta = '0;
			1: meta = pay;
			default: meta = $urandom_range(pay);
		endcase
		send_frame(pay, meta, -1, 1'b0);
	endtask

	// One random phase with its own max_payload and idling mix. With
	// pressure set, the receiver is asked for a long hold-off at the start,
	// and halfway through the sender pauses until the output has caught up.
	task automatic run_phase(input logic [31:0] maxv, input bit do_write,
		input int unsigned tx, input int unsigned rx, input bit pressure);
		logic [31:0] cap;
		bit          paused;
		if (do_write)
			write_max(maxv);
		tx_idle_pct = tx;
		rx_stall_pct <= rx;
		cap = sb.max_payload - 1;
		if (pressure)
			hold_req <= hold_req + 1;
		phase_bytes = 0;
		paused = 1'b0;
		while (phase_bytes < PHASE_BYTES) begin
			send_random_frame(cap);
			if (pressure && !paused && phase_bytes >= PHASE_BYTES / 2) begin
				drain();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		int unsigned k;
		int unsigned fault_kind;
		logic [31:0] maxv;

		sb = new(HDR_LEN);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames. The first has every free byte at 0xFF, a one-byte
		// meta part and a one-byte message part. The second is all zeros,
		// which makes an empty frame that ends on its last header byte.
		send_frame(32'd2, 32'd1, 255, 1'b0);
		send_frame(32'd0, 32'd0, 0, 1'b0);

		// Random phases. The first keeps the reset limit and runs flat out
		// with the long receiver hold-off; a limit of one allows only empty
		// frames; the all-ones limit and a wide random one sit at the top.
		run_phase(32'd0, 1'b0, 0, 0, 1'b1);
		run_phase(32'hFFFF_FFFF, 1'b1, 86, 0, 1'b0);
		run_phase(32'd1, 1'b1, 0, 86, 1'b0);
		run_phase($urandom_range(64, 2), 1'b1, 10, 10, 1'b0);
		run_phase($urandom_range(32'hFFFF_FFFF, 1000), 1'b1, 0, 0, 1'b0);

		// An error can only be cleared by reset, so it closes the run. One
		// of three faults is chosen: a zero limit that rejects every payload,
		// a payload exactly at the limit, or a meta word longer than the
		// payload. The bytes that follow must all come out discarded.
		fault_kind = $urandom_range(2);
		case (fault_kind)
			0: begin
				write_max(32'd0);
				send_frame($urandom_range(20), 32'd0, -1, 1'b1);
			end
			1: begin
				maxv = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom_range(5000, 1);
				write_max(maxv);
				send_frame(maxv, $urandom, -1, 1'b1);
			end
			default: begin
				write_max(32'hFFFF_FFFF);
				maxv = $urandom_range(50);
				send_frame(maxv, $urandom_range(1) ? 32'hFFFF_FFFF :
					maxv + 1 + $urandom_range(50), -1, 1'b1);
			end
		endcase
		for (k = 0; k < 40; k++)
			send_byte(8'($urandom));

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.tags_due.size() != 0) begin
			$error("%0d result beats never arrived", sb.tags_due.size());
			sb.fails++;
		end
		if (sb.fails == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
